>>> design/tcc_pkg.sv
// Shared types, widths and codes for the tour cycle checker.
package tcc_pkg;

    localparam int DEF_MAX_CITIES  = 256;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int CITY_W = 8;
    localparam int LEN_W  = 10;
    localparam int SUM_W  = 24;
    localparam int PNUM_W = 16;
    localparam int DIST_W = 9;

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_CITY = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        VERD_NOT_PATH  = 2'd0,
        VERD_NOT_CYCLE = 2'd1,
        VERD_TS_CYCLE  = 2'd2,
        VERD_SIMPLE    = 2'd3
    } verdict_t;

    typedef enum logic
    {
        FE_CLEAR = 1'b0,
        FE_RUN   = 1'b1
    } fe_state_t;

    // One path city on its way from the front to the back, with its edge weight.
    typedef struct packed
    {
        logic [CITY_W-1:0] city;
        logic              first;
        logic              last;
        logic [LEN_W-1:0]  edge_len;
    } city_item_t;

    typedef struct packed
    {
        logic       valid;
        city_item_t item;
    } q_push_t;

    typedef struct packed
    {
        logic       valid;
        city_item_t item;
    } q_head_t;

endpackage

>>> design/tcc_in_if.sv
// Input channel: load and path city beats.
interface tcc_in_if import tcc_pkg::*;;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [CITY_W-1:0] city_a;
    logic [CITY_W-1:0] city_b;
    logic [LEN_W-1:0]  edge_length;
    logic              opens_path;
    logic              closes_path;

    modport source (output valid, opcode, city_a, city_b, edge_length, opens_path, closes_path,
                    input ready);
    modport sink (input valid, opcode, city_a, city_b, edge_length, opens_path, closes_path,
                  output ready);
endinterface

>>> design/tcc_out_if.sv
// Output channel: one beat per finished path.
interface tcc_out_if import tcc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PNUM_W-1:0] path_number;
    logic [SUM_W-1:0]  path_length;
    logic [1:0]        verdict;
    logic [PNUM_W-1:0] best_path_number;
    logic [SUM_W-1:0]  best_length;

    modport source (output valid, path_number, path_length, verdict, best_path_number,
                    best_length, input ready);
    modport sink (input valid, path_number, path_length, verdict, best_path_number,
                  best_length, output ready);
endinterface

>>> design/tour_cycle_checker_top.sv
// Top level of the tour cycle checker: front, queue and back joined together.
//
//   channel  | kind         | content
//   ---------+--------------+---------------------------------------------------
//   item     | valid/ready  | opcode, city_a, city_b, edge_length, path open/close
//   result   | valid/ready  | path_number, path_length, verdict, best tour
//   cfg      | write enable | city_count, 8 bits, no read-back
//
// One beat is accepted per clock outside the clearing pass while the queue has room;
// a last city passes the edge read register and a queue slot into the result register.
// The rate is set by the single-port edge memory, one write or one read per beat.
// After reset the edge memory is cleared one entry a cycle, 2^(2*clog2(MAX_CITIES))
// entries (65536 at 256 cities), with item.ready low; cfg writes are taken throughout.
// A stalled result holds the back only when the next last city reaches the queue head;
// once the queue fills, item.ready drops for loads and cities alike.
module tour_cycle_checker_top import tcc_pkg::*;
#(
    parameter int MAX_CITIES  = DEF_MAX_CITIES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CITY_W-1:0] cfg_data,
    tcc_in_if.sink            item,
    tcc_out_if.source         result
);

    q_push_t                            push;
    q_head_t                            head;
    logic                               pop;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   level;

    tcc_front #(
        .MAX_CITIES  (MAX_CITIES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .level (level),
        .push  (push)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .level (level)
    );

    tcc_back #(
        .MAX_CITIES (MAX_CITIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> design/tcc_queue.sv
// Short FIFO of path cities between the front and the back.
module tcc_queue import tcc_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  q_push_t                    push,
    input  logic                       pop,
    output q_head_t                    head,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH+1);

    city_item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]       count_reg, count_next;
    logic                   do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];
    assign level      = count_reg;

    // The front reserves room before it takes a beat, so a push never meets a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !do_pop |-> count_reg != LVL_W'(DEPTH))
        else $error("tcc_queue: push into a full queue");

endmodule

>>> design/tcc_front.sv
// Front end: accepts beats, owns the edge memory and its clearing pass, looks up path edges.
module tcc_front import tcc_pkg::*;
#(
    parameter int MAX_CITIES  = DEF_MAX_CITIES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    tcc_in_if.sink                           item,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] level,
    output q_push_t                          push
);

    localparam int CIDX_W = $clog2(MAX_CITIES);
    localparam int ADDR_W = 2 * CIDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    function automatic logic in_range(input logic [CITY_W-1:0] id);
        in_range = (int'(id) < MAX_CITIES);
    endfunction

    fe_state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [CITY_W-1:0] prev_reg, prev_next;

    logic              s1_valid_reg;
    logic [CITY_W-1:0] s1_city_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic              s1_ok_reg;

    logic [LEN_W-1:0]  edge_mem [DEPTH];
    logic [LEN_W-1:0]  rdata_reg;

    logic              clearing;
    logic              room;
    logic              accept;
    logic              is_city;
    logic [CITY_W-1:0] ld_lo, ld_hi, rd_lo, rd_hi;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [LEN_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Next state of the clearing sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = FE_RUN;
                end
            end
            FE_RUN:
            begin
                state_next = FE_RUN;
            end
            default:
            begin
                state_next = FE_CLEAR;
            end
        endcase
    end

    // Outputs of the clearing sequencer.
    always_comb
    begin
        case (state_reg)
            FE_CLEAR: clearing = 1'b1;
            FE_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    // One queue slot is held back for the beat whose edge read is still in flight.
    assign room       = (int'(level) + int'(s1_valid_reg)) < QUEUE_DEPTH;
    assign item.ready = !clearing && room;
    assign accept     = item.valid && item.ready;
    assign is_city    = (item.opcode == OP_CITY);

    // Edges are kept once, under the smaller id in the high half of the address.
    assign ld_lo = (item.city_a < item.city_b) ? item.city_a : item.city_b;
    assign ld_hi = (item.city_a < item.city_b) ? item.city_b : item.city_a;
    assign rd_lo = (prev_reg < item.city_a) ? prev_reg : item.city_a;
    assign rd_hi = (prev_reg < item.city_a) ? item.city_a : prev_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {CIDX_W'(ld_lo), CIDX_W'(ld_hi)};
        mem_wdata = item.edge_length;
        if (clearing)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (accept && !is_city && in_range(item.city_a) && in_range(item.city_b))
        begin
            mem_we = 1'b1;
        end
    end

    assign mem_re    = accept && is_city;
    assign mem_raddr = {CIDX_W'(rd_lo), CIDX_W'(rd_hi)};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= edge_mem[mem_raddr];
        end
    end

    assign clr_next  = clearing ? clr_reg + 1'b1 : clr_reg;
    assign prev_next = mem_re ? item.city_a : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FE_CLEAR;
            clr_reg      <= '0;
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            prev_reg     <= prev_next;
            s1_valid_reg <= mem_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            s1_city_reg  <= item.city_a;
            s1_first_reg <= item.opens_path;
            s1_last_reg  <= item.closes_path;
            s1_ok_reg    <= in_range(prev_reg) && in_range(item.city_a);
        end
    end

    assign push.valid         = s1_valid_reg;
    assign push.item.city     = s1_city_reg;
    assign push.item.first    = s1_first_reg;
    assign push.item.last     = s1_last_reg;
    assign push.item.edge_len = s1_ok_reg ? rdata_reg : '0;

    a_city_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && item.opcode == OP_CITY |=> push.valid)
        else $error("tcc_front: accepted city beat was not pushed");

endmodule

>>> design/tcc_back.sv
// Back end: path state, visited bitmap, verdict, best tour and the result register.
module tcc_back import tcc_pkg::*;
#(
    parameter int MAX_CITIES = DEF_MAX_CITIES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CITY_W-1:0] cfg_data,
    input  q_head_t           head,
    output logic              pop,
    tcc_out_if.source         result
);

    localparam int VIS_N = (MAX_CITIES < 256) ? MAX_CITIES : 256;
    localparam int VIS_W = $clog2(VIS_N);

    logic [CITY_W-1:0] city_count_reg;
    logic [VIS_N-1:0]  visited_reg, visited_next;
    logic [CITY_W-1:0] start_reg, start_next;
    logic [SUM_W-1:0]  len_reg, len_next;
    logic              broken_reg, broken_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              repeat_reg, repeat_next;
    logic [PNUM_W-1:0] count_reg, count_next;
    logic [PNUM_W-1:0] best_idx_reg, best_idx_next;
    logic [SUM_W-1:0]  best_len_reg, best_len_next;

    logic              out_valid_reg, out_valid_next;
    logic [PNUM_W-1:0] out_num_reg;
    logic [SUM_W-1:0]  out_len_reg;
    verdict_t          out_verdict_reg;
    logic [PNUM_W-1:0] out_best_idx_reg;
    logic [SUM_W-1:0]  out_best_len_reg;

    city_item_t        cur;
    logic              in_vis;
    logic [VIS_W-1:0]  vidx;
    logic              was_seen;
    logic              closed;
    logic [SUM_W:0]    sum_wide;
    logic              qualify;
    verdict_t          verdict;
    logic [SUM_W-1:0]  sum_out;
    logic              pop_last;

    assign cur      = head.item;
    assign pop      = head.valid && (!cur.last || !out_valid_reg || result.ready);
    assign pop_last = pop && cur.last;

    assign in_vis   = (int'(cur.city) < VIS_N);
    assign vidx     = VIS_W'(cur.city);
    assign was_seen = in_vis && visited_reg[vidx];
    assign sum_wide = {1'b0, len_reg} + (SUM_W+1)'(cur.edge_len);

    always_comb
    begin
        visited_next = visited_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        broken_next  = broken_reg;
        dist_next    = dist_reg;
        repeat_next  = repeat_reg;
        closed       = 1'b0;
        if (cur.first)
        begin
            // A path start clears the bitmap in one go and counts itself.
            visited_next = '0;
            start_next   = cur.city;
            len_next     = '0;
            broken_next  = 1'b0;
            dist_next    = DIST_W'(1);
            repeat_next  = 1'b0;
            closed       = 1'b1;
        end
        else
        begin
            if (!cur.last)
            begin
                if (was_seen)
                begin
                    repeat_next = 1'b1;
                end
                else if (dist_reg != DIST_MAX)
                begin
                    dist_next = dist_reg + 1'b1;
                end
            end
            else
            begin
                closed = (cur.city == start_reg);
            end
            if (!broken_reg)
            begin
                if (cur.edge_len == '0)
                begin
                    broken_next = 1'b1;
                end
                else
                begin
                    len_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                end
            end
        end
        if (in_vis)
        begin
            visited_next[vidx] = 1'b1;
        end
    end

    always_comb
    begin
        count_next    = count_reg + 1'b1;
        best_idx_next = best_idx_reg;
        best_len_next = best_len_reg;
        qualify       = !broken_next && closed && (dist_next == DIST_W'(city_count_reg));
        if (broken_next)
        begin
            verdict = VERD_NOT_PATH;
            sum_out = '0;
        end
        else
        begin
            sum_out = len_next;
            if (qualify)
            begin
                verdict = repeat_next ? VERD_TS_CYCLE : VERD_SIMPLE;
            end
            else
            begin
                verdict = VERD_NOT_CYCLE;
            end
        end
        if (qualify && (best_len_reg == '0 || len_next < best_len_reg))
        begin
            best_idx_next = count_next;
            best_len_next = len_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CITY_W'(1);
            visited_reg    <= '0;
            start_reg      <= '0;
            len_reg        <= '0;
            broken_reg     <= 1'b0;
            dist_reg       <= '0;
            repeat_reg     <= 1'b0;
            count_reg      <= '0;
            best_idx_reg   <= '0;
            best_len_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                city_count_reg <= cfg_data;
            end
            if (pop)
            begin
                visited_reg <= visited_next;
                start_reg   <= start_next;
                len_reg     <= len_next;
                broken_reg  <= broken_next;
                dist_reg    <= dist_next;
                repeat_reg  <= repeat_next;
            end
            if (pop_last)
            begin
                count_reg    <= count_next;
                best_idx_reg <= best_idx_next;
                best_len_reg <= best_len_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_last)
        begin
            out_num_reg      <= count_next;
            out_len_reg      <= sum_out;
            out_verdict_reg  <= verdict;
            out_best_idx_reg <= best_idx_next;
            out_best_len_reg <= best_len_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.path_number      = out_num_reg;
    assign result.path_length      = out_len_reg;
    assign result.verdict          = out_verdict_reg;
    assign result.best_path_number = out_best_idx_reg;
    assign result.best_length      = out_best_len_reg;

    a_broken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.verdict == VERD_NOT_PATH |-> result.path_length == '0)
        else $error("tcc_back: broken path reports a nonzero length");

    a_best_not_worse: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.verdict == VERD_TS_CYCLE || result.verdict == VERD_SIMPLE)
        |-> result.best_length <= result.path_length)
        else $error("tcc_back: best tour longer than a qualifying tour");

    a_best_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !pop_last |=> $stable(best_len_reg) && $stable(best_idx_reg))
        else $error("tcc_back: best tour changed without a finished path");

endmodule
